// File: src/ansi_text_terminal_engine_defines.svh
// Assertion macros used by the terminal engine checker.
// The using module must provide clk and rst in scope.
`ifndef ANSI_TEXT_TERMINAL_ENGINE_DEFINES_SVH
`define ANSI_TEXT_TERMINAL_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ATTE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("terminal engine check failed");

// Next-cycle implication, disabled during reset.
`define ATTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("terminal engine check failed");

`endif

// File: src/atte_pkg.sv
// Shared types and constants for the ANSI text terminal engine.
// Used by the cell memory, the top level and the checker; depends on nothing.
package atte_pkg;

  localparam int SCREEN_LINES = 25;
  localparam int LINE_LENGTH  = 80;
  localparam int CELL_COUNT   = SCREEN_LINES * LINE_LENGTH;
  localparam int ADDR_W       = $clog2(CELL_COUNT);

  // Port widths fixed by the interface.
  localparam int ROW_W = 5;
  localparam int COL_W = 7;
  localparam int SUM_W = ROW_W + 2;
  localparam int ROW_MAX = (1 << ROW_W) - 1;
  localparam int MOD_STEPS = (ROW_MAX + SCREEN_LINES - 1) / SCREEN_LINES;
  localparam int CLR_W = $clog2(LINE_LENGTH);

  localparam int NUM_W  = 10;
  localparam int PROD_W = 14;

  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_ESC      = 8'd27;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_M        = 8'h6D;

  localparam logic [7:0] BLANK_ATTR  = 8'hF0;
  localparam logic [7:0] CURSOR_ATTR = 8'h0F;
  localparam logic [7:0] INVERT_MASK = 8'hFF;

  localparam logic [NUM_W-1:0] FG_FIRST  = 10'd30;
  localparam logic [NUM_W-1:0] FG_LAST   = 10'd37;
  localparam logic [NUM_W-1:0] FG_BRIGHT = 10'd8;
  localparam logic [NUM_W-1:0] BG_FIRST  = 10'd40;
  localparam logic [NUM_W-1:0] BG_LAST   = 10'd47;
  localparam logic [NUM_W-1:0] NUM_MAX   = 10'd999;

  localparam logic FUNC_CONSUME = 1'b0;
  localparam logic FUNC_READ    = 1'b1;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
  } cell_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    cell_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// File: src/atte_cell_mem.sv
// Screen cell memory: one write port and one read port, registered read data.
// Depends on atte_pkg for the cell type and the request struct.
module atte_cell_mem import atte_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output cell_t    rdata
);

  cell_t mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// File: src/ansi_text_terminal_engine.sv
// ANSI text terminal engine: a byte stream drawn into a ring of text lines.
// Every accepted item passes through decode, a result read and a done state that holds while
// the output stalls, and the next item is taken after its result; a printable byte adds the
// cursor read-modify-write, backspace adds it plus a step back and a store, and line feed adds
// it plus a line advance and the line clear. The cell memory takes at most one access per cycle.
// Synchronous reset runs a clearing pass over all CELL_COUNT (2000) cells; no item is taken then.
module ansi_text_terminal_engine import atte_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             func,
  input  logic [7:0]       stream_byte,
  input  logic [ROW_W-1:0] read_row,
  input  logic [COL_W-1:0] read_col,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       cell_char,
  output logic [7:0]       cell_attr,
  output logic [COL_W-1:0] cursor_col,
  output logic [ROW_W-1:0] cursor_row,
  output logic [ROW_W-1:0] scroll_offset,
  output logic [7:0]       style
);

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DECODE = 4'd2;
  localparam logic [3:0] ST_TOG_RD = 4'd3;
  localparam logic [3:0] ST_TOG_WR = 4'd4;
  localparam logic [3:0] ST_LF_ADV = 4'd5;
  localparam logic [3:0] ST_LF_CLR = 4'd6;
  localparam logic [3:0] ST_BS_DEC = 4'd7;
  localparam logic [3:0] ST_BS_PUT = 4'd8;
  localparam logic [3:0] ST_READ   = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_CSI  = 2'd2;

  logic [3:0] state, state_next;
  logic [3:0] after_tog, after_tog_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic [CLR_W-1:0] clr_col, clr_col_next;

  logic             op_func, op_func_next;
  logic [7:0]       op_byte, op_byte_next;
  logic [ROW_W-1:0] op_row, op_row_next;
  logic [COL_W-1:0] op_col, op_col_next;

  logic [COL_W-1:0] col_pos, col_pos_next;
  logic [ROW_W-1:0] row_pos, row_pos_next;
  logic [ROW_W-1:0] top_line, top_line_next;
  logic [7:0]       cur_style, cur_style_next;
  logic [1:0]       parse_phase, parse_phase_next;
  logic [NUM_W-1:0] escape_number, escape_number_next;

  logic             out_valid_next;
  logic [7:0]       cell_char_next, cell_attr_next;

  mem_req_t mem_req;
  cell_t    rdata;

  logic [ROW_W:0]    cur_sum;
  logic [ROW_W-1:0]  cur_line;
  logic [ADDR_W-1:0] cur_addr;
  logic [SUM_W-1:0]  rd_sum;
  logic [ADDR_W-1:0] rd_addr;
  logic              col_ok;

  logic [ROW_W-1:0]  y_adv, top_adv;
  logic [PROD_W-1:0] num_prod;
  logic              is_digit;

  atte_cell_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  assign in_stall = (state != ST_IDLE);

  // Physical address of the cursor cell.
  always_comb begin
    cur_sum  = {1'b0, row_pos} + {1'b0, top_line};
    cur_line = (cur_sum >= (ROW_W + 1)'(SCREEN_LINES)) ?
               ROW_W'(cur_sum - (ROW_W + 1)'(SCREEN_LINES)) : ROW_W'(cur_sum);
    cur_addr = ADDR_W'(cur_line) * ADDR_W'(LINE_LENGTH) + ADDR_W'(col_pos);
  end

  // Read row maps through the scroll offset and wraps past the screen.
  always_comb begin
    rd_sum = SUM_W'(op_row) + SUM_W'(top_line);
    for (int i = 0; i < MOD_STEPS; i++) begin
      if (rd_sum >= SUM_W'(SCREEN_LINES)) begin
        rd_sum = rd_sum - SUM_W'(SCREEN_LINES);
      end
    end
    rd_addr = ADDR_W'(rd_sum) * ADDR_W'(LINE_LENGTH) + ADDR_W'(op_col);
    col_ok  = (op_col < COL_W'(LINE_LENGTH));
  end

  // Next row position, scrolling the ring at the bottom.
  always_comb begin
    if (row_pos == ROW_W'(SCREEN_LINES - 1)) begin
      y_adv   = row_pos;
      top_adv = (top_line == ROW_W'(SCREEN_LINES - 1)) ? '0 : top_line + 1'b1;
    end else begin
      y_adv   = row_pos + 1'b1;
      top_adv = top_line;
    end
  end

  always_comb begin
    is_digit = (op_byte >= CH_ZERO) && (op_byte <= CH_NINE);
    num_prod = (PROD_W'(escape_number) << 3) + (PROD_W'(escape_number) << 1)
               + PROD_W'(op_byte[3:0]);
  end

  always_comb begin
    state_next         = state;
    after_tog_next     = after_tog;
    clr_addr_next      = clr_addr;
    clr_col_next       = clr_col;
    op_func_next       = op_func;
    op_byte_next       = op_byte;
    op_row_next        = op_row;
    op_col_next        = op_col;
    col_pos_next       = col_pos;
    row_pos_next       = row_pos;
    top_line_next      = top_line;
    cur_style_next     = cur_style;
    parse_phase_next   = parse_phase;
    escape_number_next = escape_number;
    out_valid_next     = out_valid && out_stall;
    cell_char_next     = cell_char;
    cell_attr_next     = cell_attr;

    mem_req.we          = 1'b0;
    mem_req.waddr       = cur_addr;
    mem_req.wdata.ch    = CH_SPACE;
    mem_req.wdata.attr  = BLANK_ATTR;
    mem_req.re          = 1'b0;
    mem_req.raddr       = cur_addr;

    case (state)
      ST_CLR: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = clr_addr;
        mem_req.wdata.attr = (clr_addr == '0) ? CURSOR_ATTR : BLANK_ATTR;
        if (clr_addr == ADDR_W'(CELL_COUNT - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_func_next = func;
          op_byte_next = stream_byte;
          op_row_next  = read_row;
          op_col_next  = read_col;
          state_next   = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_next = ST_READ;
        if (op_func == FUNC_CONSUME) begin
          case (parse_phase)
            PH_ESC: begin
              if (op_byte == CH_LBRACKET) begin
                parse_phase_next   = PH_CSI;
                escape_number_next = '0;
              end else begin
                parse_phase_next = PH_IDLE;
              end
            end

            PH_CSI: begin
              if (is_digit) begin
                escape_number_next = (num_prod > PROD_W'(NUM_MAX)) ?
                                     NUM_MAX : NUM_W'(num_prod);
              end else begin
                if (op_byte == CH_M) begin
                  if (escape_number >= FG_FIRST && escape_number <= FG_LAST) begin
                    cur_style_next = {4'(escape_number - FG_FIRST + FG_BRIGHT),
                                      cur_style[3:0]};
                  end else if (escape_number >= BG_FIRST && escape_number <= BG_LAST) begin
                    cur_style_next = {cur_style[7:4], 4'(escape_number - BG_FIRST)};
                  end
                end
                parse_phase_next   = PH_IDLE;
                escape_number_next = '0;
              end
            end

            default: begin
              parse_phase_next = PH_IDLE;
              if (op_byte[7]) begin
                state_next = ST_READ;
              end else if (op_byte >= CH_SPACE) begin
                // Store over the cursor cell, then advance and mark the new cell.
                mem_req.we         = 1'b1;
                mem_req.wdata.ch   = op_byte;
                mem_req.wdata.attr = cur_style;
                if (col_pos == COL_W'(LINE_LENGTH - 1)) begin
                  col_pos_next  = '0;
                  row_pos_next  = y_adv;
                  top_line_next = top_adv;
                end else begin
                  col_pos_next = col_pos + 1'b1;
                end
                after_tog_next = ST_READ;
                state_next     = ST_TOG_RD;
              end else if (op_byte == CH_LF) begin
                after_tog_next = ST_LF_ADV;
                state_next     = ST_TOG_RD;
              end else if (op_byte == CH_BS && col_pos != '0) begin
                after_tog_next = ST_BS_DEC;
                state_next     = ST_TOG_RD;
              end else if (op_byte == CH_ESC) begin
                parse_phase_next   = PH_ESC;
                escape_number_next = '0;
              end
            end
          endcase
        end
      end

      ST_TOG_RD: begin
        mem_req.re = 1'b1;
        state_next = ST_TOG_WR;
      end

      ST_TOG_WR: begin
        mem_req.we         = 1'b1;
        mem_req.wdata.ch   = rdata.ch;
        mem_req.wdata.attr = rdata.attr ^ INVERT_MASK;
        state_next         = after_tog;
      end

      ST_LF_ADV: begin
        col_pos_next  = '0;
        row_pos_next  = y_adv;
        top_line_next = top_adv;
        clr_col_next  = '0;
        state_next    = ST_LF_CLR;
      end

      ST_LF_CLR: begin
        // The cursor sits at column zero, so that cell is written already inverted.
        mem_req.we         = 1'b1;
        mem_req.waddr      = cur_addr + ADDR_W'(clr_col);
        mem_req.wdata.attr = (clr_col == '0) ? CURSOR_ATTR : BLANK_ATTR;
        if (clr_col == CLR_W'(LINE_LENGTH - 1)) begin
          state_next = ST_READ;
        end else begin
          clr_col_next = clr_col + 1'b1;
        end
      end

      ST_BS_DEC: begin
        col_pos_next = col_pos - 1'b1;
        state_next   = ST_BS_PUT;
      end

      ST_BS_PUT: begin
        mem_req.we         = 1'b1;
        mem_req.wdata.attr = cur_style ^ INVERT_MASK;
        state_next         = ST_READ;
      end

      ST_READ: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = rd_addr;
        state_next    = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          cell_char_next = col_ok ? rdata.ch : '0;
          cell_attr_next = col_ok ? rdata.attr : '0;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      after_tog     <= ST_READ;
      clr_addr      <= '0;
      clr_col       <= '0;
      col_pos       <= '0;
      row_pos       <= '0;
      top_line      <= '0;
      cur_style     <= BLANK_ATTR;
      parse_phase   <= PH_IDLE;
      escape_number <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      after_tog     <= after_tog_next;
      clr_addr      <= clr_addr_next;
      clr_col       <= clr_col_next;
      col_pos       <= col_pos_next;
      row_pos       <= row_pos_next;
      top_line      <= top_line_next;
      cur_style     <= cur_style_next;
      parse_phase   <= parse_phase_next;
      escape_number <= escape_number_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_func   <= op_func_next;
    op_byte   <= op_byte_next;
    op_row    <= op_row_next;
    op_col    <= op_col_next;
    cell_char <= cell_char_next;
    cell_attr <= cell_attr_next;
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      cursor_col    <= col_pos;
      cursor_row    <= row_pos;
      scroll_offset <= top_line;
      style         <= cur_style;
    end
  end

endmodule

// File: src/atte_checker.sv
// Port-level checks for the ANSI text terminal engine, bound to the top level.
// Depends on atte_pkg and the assertion macros header.
`include "ansi_text_terminal_engine_defines.svh"

module atte_checker import atte_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [7:0]       cell_char,
  input logic [7:0]       cell_attr,
  input logic [COL_W-1:0] cursor_col,
  input logic [ROW_W-1:0] cursor_row,
  input logic [ROW_W-1:0] scroll_offset,
  input logic [7:0]       style
);

  // A waiting result holds until its transfer.
  `ATTE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cell_char) && $stable(cell_attr) && $stable(cursor_col) && $stable(style))

  // One item at a time: the block is busy right after taking an item.
  `ATTE_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)

  // The cursor and the scroll offset stay on the screen whenever a result is valid.
  `ATTE_ASSERT_IMPL(a_cursor_range, out_valid, cursor_col < LINE_LENGTH && cursor_row < SCREEN_LINES && scroll_offset < SCREEN_LINES)

  // High bytes are never stored, so no cell reads back one.
  `ATTE_ASSERT_IMPL(a_char_seven_bit, out_valid, !cell_char[7])

endmodule

bind ansi_text_terminal_engine atte_checker u_atte_checker (.*);
